@@ sv/mmsm_pkg.sv @@
// Shared types, constants and sequencer states of the mean and deviation monitor.
package mmsm_pkg;

  localparam int SAMPLE_BITS         = 16;
  localparam int MAX_PACKAGE_SAMPLES = 256;
  localparam int CH_W                = 5;
  localparam int VAL_W               = 24;
  localparam int PCNT_W              = 9;
  localparam int CFG_IDX_W           = 2;
  localparam int CFG_DATA_W          = 16;
  localparam int MUL_W               = 24;
  localparam int PROD_W              = 2 * MUL_W;
  localparam int DIV_DVD_W           = 66;
  localparam int DIV_DSR_W           = 17;
  localparam int DIV_Q_W             = 64;
  localparam int SQRT_W              = 64;
  localparam int ROOT_W              = SQRT_W / 2;

  localparam logic [CFG_IDX_W-1:0] CFG_UNIT_PACKAGES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UNITS_PER_MEAN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STD_WINDOW     = 2'd2;

  localparam logic [PCNT_W-1:0] PCNT_MAX         = PCNT_W'(MAX_PACKAGE_SAMPLES);
  localparam logic [10:0]       MEAN_COUNT_MAX   = 11'd2047;
  localparam logic [3:0]        UNIT_COUNT_MAX   = 4'd15;
  localparam logic [17:0]       WINDOW_COUNT_MAX = 18'd131071;
  localparam logic [VAL_W-1:0]  DEV_MAX          = 24'hFFFFFF;

  typedef struct packed {
    logic signed [24:0] psum;
    logic [PCNT_W-1:0]  pcnt;
    logic [38:0]        psq;
    logic signed [34:0] msum;
    logic [10:0]        mcnt;
    logic signed [27:0] usum;
    logic [3:0]         ucnt;
    logic signed [23:0] lmean;
    logic signed [33:0] wsum;
    logic [47:0]        wsq;
    logic [16:0]        wcnt;
  } entry_t;

  typedef struct packed {
    logic [CH_W-1:0]  channel;
    logic             uv;
    logic [VAL_W-1:0] um;
    logic             lv;
    logic [VAL_W-1:0] lm;
    logic             dv;
    logic [VAL_W-1:0] dev;
    logic             last;
  } result_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LOAD,
    S_UPD,
    S_PDIV,
    S_WB,
    B_START,
    B_RD,
    B_LOAD,
    B_MEAN,
    B_MDIV,
    B_DEV,
    B_DMUL,
    B_DACC,
    B_DCOMB,
    B_DDIV,
    B_SQRT,
    B_EMIT,
    B_WB,
    B_FLUSH
  } state_t;

endpackage

@@ sv/multichannel_mean_std_monitor_top.sv @@
// Multichannel package mean, unit mean, long mean and standard deviation monitor.
// A sample item that closes no package goes through these steps before the next is accepted:
// accept, per-channel state read, square through the shared 24x24 multiplier, and
// update with writeback. A package end adds a pass of the bit-serial divider.
// An item with packet end that finds a trigger latched then walks every channel,
// adding per channel a unit or long mean division and, for the deviation, five
// multiplier steps, one division and a root. Results of a burst leave through a two-deep
// output stage; the walk waits only when both entries are full and the sink stalls.
// Per-channel state sits in a single-port memory whose entries read as zero until first
// written.
module multichannel_mean_std_monitor_top #(
  parameter int CHANNELS = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [mmsm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mmsm_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [mmsm_pkg::CH_W-1:0]          in_channel,
  input  logic signed [mmsm_pkg::SAMPLE_BITS-1:0] in_sample,
  input  logic                               in_sample_valid,
  input  logic                               in_package_end,
  input  logic                               in_packet_end,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [mmsm_pkg::CH_W-1:0]          out_channel,
  output logic                               out_unit_mean_valid,
  output logic signed [mmsm_pkg::VAL_W-1:0]  out_unit_mean,
  output logic                               out_long_mean_valid,
  output logic signed [mmsm_pkg::VAL_W-1:0]  out_long_mean,
  output logic                               out_deviation_valid,
  output logic [mmsm_pkg::VAL_W-1:0]         out_deviation,
  output logic                               out_last
);
  import mmsm_pkg::*;

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // configuration
  logic [10:0] unit_packages_r;
  logic [3:0]  units_per_mean_r;
  logic [15:0] std_window_r;

  // sequencer
  state_t state_r, state_nxt;

  // accepted item
  logic [CH_W-1:0]               it_ch_r;
  logic signed [SAMPLE_BITS-1:0] it_s_r;
  logic                          it_sv_r;
  logic                          it_pe_r;
  logic                          it_ke_r;

  // channel state memory
  entry_t              mem_r [CHANNELS];
  logic [CHANNELS-1:0] vld_r;
  entry_t              rd_q_r;
  logic                rd_vld_r;
  entry_t              ent;
  entry_t              rec_r;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;

  // triggers and burst
  logic          mean_armed_r;
  logic          dev_armed_r;
  logic [3:0]    phase_r;
  logic          b_mean_r;
  logic          b_long_r;
  logic          b_dev_r;
  logic [AW-1:0] idx_r;
  logic          idx_last;

  // results
  result_t res_r;
  result_t pend_r;
  logic    pend_vld_r;
  result_t out_r;
  result_t out_nxt;
  logic    out_vld_r;
  logic    res_any;
  logic    out_free;
  logic    load_out;

  // deviation datapath
  logic [2:0]        dstep_r;
  logic [MUL_W-1:0]  am_r;
  logic [33:0]       as1_r;
  logic              t3neg_r;
  logic [PROD_W-1:0] sq_r;
  logic [DIV_DVD_W-1:0] acc_r;
  logic [63:0]       t3_r;

  // shared multiplier
  logic [MUL_W-1:0]  mul_a;
  logic [MUL_W-1:0]  mul_b;
  logic [PROD_W-1:0] prod_r;

  // divider and root
  logic                 div_start;
  logic [DIV_DVD_W-1:0] div_dvd;
  logic [DIV_DSR_W-1:0] div_dsr;
  logic                 div_neg;
  logic                 div_done;
  logic [DIV_Q_W-1:0]   div_q;
  logic                 sqrt_start;
  logic                 sqrt_done;
  logic [ROOT_W-1:0]    sqrt_root;

  // item update terms
  logic                 in_ch_ok;
  logic [16:0]          s_ext;
  logic [16:0]          s_abs;
  logic                 samp_take;
  logic signed [24:0]   psum_new;
  logic [38:0]          psq_new;
  logic [PCNT_W-1:0]    pcnt_new;
  logic [32:0]          px256;
  logic [32:0]          px_abs;
  logic                 pkg_go;
  logic                 mcnt_ok;
  logic [10:0]          mcnt_new;
  logic [17:0]          wcnt_sum;
  logic                 win_ok;
  logic [16:0]          wcnt_new;
  logic [34:0]          msum_abs;
  logic [27:0]          usum_abs;
  logic [MUL_W-1:0]     lm_abs;
  logic [33:0]          ws_abs;
  logic                 mean_go;
  logic                 dev_go;
  logic [DIV_DVD_W-1:0] dev_dvd;

  mmsm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .negate   (div_neg),
    .done     (div_done),
    .quotient (div_q)
  );

  mmsm_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .value (div_q),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  assign in_ch_ok = (32'(in_channel) < 32'(CHANNELS));
  assign ent      = rd_vld_r ? rd_q_r : '0;
  assign idx_last = (idx_r == AW'(CHANNELS - 1));
  assign res_any  = res_r.uv | res_r.lv | res_r.dv;
  assign out_free = !out_vld_r || !out_stall;

  assign s_ext     = 17'(it_s_r);
  assign s_abs     = s_ext[16] ? (17'd0 - s_ext) : s_ext;
  assign samp_take = it_sv_r && (rec_r.pcnt < PCNT_MAX);
  assign psum_new  = samp_take ? (rec_r.psum + 25'(it_s_r)) : rec_r.psum;
  assign psq_new   = samp_take ? (rec_r.psq + 39'(prod_r)) : rec_r.psq;
  assign pcnt_new  = samp_take ? (rec_r.pcnt + PCNT_W'(1)) : rec_r.pcnt;
  assign px256     = {psum_new, 8'h00};
  assign px_abs    = px256[32] ? (33'd0 - px256) : px256;
  assign pkg_go    = it_pe_r && (pcnt_new != '0);

  assign mcnt_ok  = (rec_r.mcnt < MEAN_COUNT_MAX);
  assign mcnt_new = mcnt_ok ? (rec_r.mcnt + 11'd1) : rec_r.mcnt;
  assign wcnt_sum = {1'b0, rec_r.wcnt} + 18'(rec_r.pcnt);
  assign win_ok   = (wcnt_sum <= WINDOW_COUNT_MAX);
  assign wcnt_new = win_ok ? wcnt_sum[16:0] : rec_r.wcnt;

  assign msum_abs = rec_r.msum[34] ? (35'd0 - rec_r.msum) : rec_r.msum;
  assign usum_abs = rec_r.usum[27] ? (28'd0 - rec_r.usum) : rec_r.usum;
  assign lm_abs   = rec_r.lmean[23] ? (24'd0 - rec_r.lmean) : rec_r.lmean;
  assign ws_abs   = rec_r.wsum[33] ? (34'd0 - rec_r.wsum) : rec_r.wsum;
  assign mean_go  = b_mean_r && (b_long_r ? (rec_r.ucnt != '0) : (rec_r.mcnt != '0));
  assign dev_go   = b_dev_r && (rec_r.wcnt != '0);
  assign dev_dvd  = t3neg_r ? (acc_r + {2'b00, t3_r}) : (acc_r - {2'b00, t3_r});

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_packages_r  <= 11'd5;
      units_per_mean_r <= 4'd4;
      std_window_r     <= 16'd3000;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_UNIT_PACKAGES:  unit_packages_r  <= cfg_data[10:0];
        CFG_UNITS_PER_MEAN: units_per_mean_r <= cfg_data[3:0];
        CFG_STD_WINDOW:     std_window_r     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_ch_ok) state_nxt = S_LOAD;
          else if (in_packet_end) state_nxt = B_START;
        end
      end
      S_LOAD:  state_nxt = S_UPD;
      S_UPD:   state_nxt = pkg_go ? S_PDIV : S_WB;
      S_PDIV:  if (div_done) state_nxt = S_WB;
      S_WB:    state_nxt = it_ke_r ? B_START : S_IDLE;
      B_START: state_nxt = (mean_armed_r || dev_armed_r) ? B_RD : S_IDLE;
      B_RD:    state_nxt = B_LOAD;
      B_LOAD:  state_nxt = B_MEAN;
      B_MEAN:  state_nxt = mean_go ? B_MDIV : B_DEV;
      B_MDIV:  if (div_done) state_nxt = B_DEV;
      B_DEV:   state_nxt = dev_go ? B_DMUL : B_EMIT;
      B_DMUL:  state_nxt = B_DACC;
      B_DACC:  state_nxt = (dstep_r == 3'd4) ? B_DCOMB : B_DMUL;
      B_DCOMB: state_nxt = B_DDIV;
      B_DDIV:  if (div_done) state_nxt = B_SQRT;
      B_SQRT:  if (sqrt_done) state_nxt = B_EMIT;
      B_EMIT: begin
        if (!res_any || !pend_vld_r || out_free) state_nxt = B_WB;
      end
      B_WB:    state_nxt = idx_last ? B_FLUSH : B_RD;
      B_FLUSH: if (!pend_vld_r || out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall   = 1'b1;
    rd_en      = 1'b0;
    rd_addr    = idx_r;
    wr_en      = 1'b0;
    wr_addr    = idx_r;
    mul_a      = am_r;
    mul_b      = am_r;
    div_start  = 1'b0;
    div_dvd    = dev_dvd;
    div_dsr    = rec_r.wcnt;
    div_neg    = 1'b0;
    sqrt_start = 1'b0;
    load_out   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        rd_en    = in_valid;
        rd_addr  = AW'(in_channel);
      end
      S_LOAD: begin
        mul_a = MUL_W'(s_abs);
        mul_b = MUL_W'(s_abs);
      end
      S_UPD: begin
        div_start = pkg_go;
        div_dvd   = DIV_DVD_W'(px_abs);
        div_dsr   = DIV_DSR_W'(pcnt_new);
        div_neg   = psum_new[24];
      end
      S_WB: begin
        wr_en   = 1'b1;
        wr_addr = AW'(it_ch_r);
      end
      B_RD: rd_en = 1'b1;
      B_MEAN: begin
        div_start = mean_go;
        if (b_long_r) begin
          div_dvd = DIV_DVD_W'(usum_abs);
          div_dsr = DIV_DSR_W'(rec_r.ucnt);
          div_neg = rec_r.usum[27];
        end else begin
          div_dvd = DIV_DVD_W'(msum_abs);
          div_dsr = DIV_DSR_W'(rec_r.mcnt);
          div_neg = rec_r.msum[34];
        end
      end
      B_DMUL: begin
        unique case (dstep_r)
          3'd1: begin
            mul_a = sq_r[23:0];
            mul_b = MUL_W'(rec_r.wcnt);
          end
          3'd2: begin
            mul_a = sq_r[47:24];
            mul_b = MUL_W'(rec_r.wcnt);
          end
          3'd3: mul_b = as1_r[23:0];
          3'd4: mul_b = MUL_W'(as1_r[33:24]);
          default: ;
        endcase
      end
      B_DCOMB: div_start = 1'b1;
      B_DDIV:  sqrt_start = div_done;
      B_EMIT:  load_out = res_any && pend_vld_r && out_free;
      B_WB:    wr_en = 1'b1;
      B_FLUSH: load_out = pend_vld_r && out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_nxt      = pend_r;
    out_nxt.last = (state_r == B_FLUSH);
  end

  // state memory
  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_addr] <= rec_r;
    if (rd_en) rd_q_r <= mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) vld_r[wr_addr] <= 1'b1;
      if (rd_en) rd_vld_r <= vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      mean_armed_r <= 1'b0;
      dev_armed_r  <= 1'b0;
      phase_r      <= '0;
      b_mean_r     <= 1'b0;
      b_long_r     <= 1'b0;
      b_dev_r      <= 1'b0;
      idx_r        <= '0;
      dstep_r      <= '0;
      pend_vld_r   <= 1'b0;
      out_vld_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) out_vld_r <= 1'b1;
      else if (!out_stall) out_vld_r <= 1'b0;
      unique case (state_r)
        S_PDIV: begin
          if (div_done && it_ch_r == '0) begin
            if (mcnt_new >= unit_packages_r) mean_armed_r <= 1'b1;
            if (wcnt_new >= 17'(std_window_r)) dev_armed_r <= 1'b1;
          end
        end
        B_START: begin
          b_mean_r     <= mean_armed_r;
          b_long_r     <= !(phase_r < units_per_mean_r);
          b_dev_r      <= dev_armed_r;
          mean_armed_r <= 1'b0;
          dev_armed_r  <= 1'b0;
          idx_r        <= '0;
          if (mean_armed_r) begin
            phase_r <= (phase_r < units_per_mean_r) ? (phase_r + 4'd1) : 4'd0;
          end
        end
        B_DEV:  dstep_r <= '0;
        B_DACC: dstep_r <= dstep_r + 3'd1;
        B_EMIT: begin
          if (res_any && (!pend_vld_r || out_free)) pend_vld_r <= 1'b1;
        end
        B_WB: idx_r <= idx_r + AW'(1);
        B_FLUSH: begin
          if (out_free) pend_vld_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (load_out) out_r <= out_nxt;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          it_ch_r <= in_channel;
          it_s_r  <= in_sample;
          it_sv_r <= in_sample_valid;
          it_pe_r <= in_package_end;
          it_ke_r <= in_packet_end;
        end
      end
      S_LOAD: rec_r <= ent;
      S_UPD: begin
        rec_r.psum <= psum_new;
        rec_r.psq  <= psq_new;
        rec_r.pcnt <= pcnt_new;
      end
      S_PDIV: begin
        if (div_done) begin
          if (mcnt_ok) begin
            rec_r.msum <= rec_r.msum + 35'(div_q);
            rec_r.mcnt <= mcnt_new;
          end
          if (win_ok) begin
            rec_r.wsum <= rec_r.wsum + 34'(rec_r.psum);
            rec_r.wsq  <= rec_r.wsq + 48'(rec_r.psq);
            rec_r.wcnt <= wcnt_new;
          end
          rec_r.psum <= '0;
          rec_r.psq  <= '0;
          rec_r.pcnt <= '0;
        end
      end
      B_RD: res_r <= '0;
      B_LOAD: begin
        rec_r         <= ent;
        res_r.channel <= CH_W'(idx_r);
      end
      B_MDIV: begin
        if (div_done) begin
          if (b_long_r) begin
            res_r.lv    <= 1'b1;
            res_r.lm    <= div_q[VAL_W-1:0];
            rec_r.lmean <= div_q[VAL_W-1:0];
            rec_r.usum  <= '0;
            rec_r.ucnt  <= '0;
          end else begin
            res_r.uv <= 1'b1;
            res_r.um <= div_q[VAL_W-1:0];
            if (rec_r.ucnt < UNIT_COUNT_MAX) begin
              rec_r.usum <= rec_r.usum + 28'(div_q);
              rec_r.ucnt <= rec_r.ucnt + 4'd1;
            end
            rec_r.msum <= '0;
            rec_r.mcnt <= '0;
          end
        end
      end
      B_DEV: begin
        am_r    <= lm_abs;
        as1_r   <= ws_abs;
        t3neg_r <= rec_r.lmean[23] != rec_r.wsum[33];
      end
      B_DACC: begin
        unique case (dstep_r)
          3'd0: sq_r <= prod_r;
          3'd1: acc_r <= {2'b00, rec_r.wsq, 16'h0000} + DIV_DVD_W'(prod_r);
          3'd2: acc_r <= acc_r + (DIV_DVD_W'(prod_r) << 24);
          3'd3: t3_r <= 64'(prod_r) << 9;
          3'd4: t3_r <= t3_r + (64'(prod_r) << 33);
          default: ;
        endcase
      end
      B_SQRT: begin
        if (sqrt_done) begin
          res_r.dv   <= 1'b1;
          res_r.dev  <= (|sqrt_root[ROOT_W-1:VAL_W]) ? DEV_MAX : sqrt_root[VAL_W-1:0];
          rec_r.wsum <= '0;
          rec_r.wsq  <= '0;
          rec_r.wcnt <= '0;
        end
      end
      B_EMIT: begin
        if (res_any && (!pend_vld_r || out_free)) pend_r <= res_r;
      end
      default: ;
    endcase
  end

  assign out_valid           = out_vld_r;
  assign out_channel         = out_r.channel;
  assign out_unit_mean_valid = out_r.uv;
  assign out_unit_mean       = out_r.um;
  assign out_long_mean_valid = out_r.lv;
  assign out_long_mean       = out_r.lm;
  assign out_deviation_valid = out_r.dv;
  assign out_deviation       = out_r.dev;
  assign out_last            = out_r.last;

endmodule

@@ sv/mmsm_div.sv @@
// Restoring divider, one quotient bit per cycle, sign applied to the quotient.
module mmsm_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [mmsm_pkg::DIV_DVD_W-1:0] dividend,
  input  logic [mmsm_pkg::DIV_DSR_W-1:0] divisor,
  input  logic                           negate,
  output logic                           done,
  output logic [mmsm_pkg::DIV_Q_W-1:0]   quotient
);
  import mmsm_pkg::*;

  localparam int CNT_W = $clog2(DIV_DVD_W + 1);

  logic                 busy_r;
  logic                 done_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [DIV_DVD_W-1:0] dvd_r;
  logic [DIV_DSR_W-1:0] rem_r;
  logic [DIV_DSR_W-1:0] dsr_r;
  logic                 neg_r;
  logic [DIV_DSR_W:0]   shifted;
  logic [DIV_DSR_W+1:0] diff;
  logic                 ge;
  logic [DIV_Q_W-1:0]   q_mag;

  assign shifted = {rem_r, dvd_r[DIV_DVD_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dsr_r};
  assign ge      = !diff[DIV_DSR_W+1];
  assign q_mag   = dvd_r[DIV_Q_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DIV_DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
      neg_r <= negate;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DIV_DVD_W-2:0], ge};
      rem_r <= ge ? diff[DIV_DSR_W-1:0] : shifted[DIV_DSR_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? (DIV_Q_W'(0) - q_mag) : q_mag;

endmodule

@@ sv/mmsm_sqrt.sv @@
// Integer square root, one root bit per cycle.
module mmsm_sqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [mmsm_pkg::SQRT_W-1:0]  value,
  output logic                         done,
  output logic [mmsm_pkg::ROOT_W-1:0]  root
);
  import mmsm_pkg::*;

  localparam int CNT_W = $clog2(ROOT_W);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [SQRT_W-1:0] v_r;
  logic [SQRT_W-1:0] r_r;
  logic [SQRT_W-1:0] b_r;
  logic [SQRT_W-1:0] trial;
  logic              ge;

  assign trial = r_r + b_r;
  assign ge    = (v_r >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(ROOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r <= value;
      r_r <= '0;
      b_r <= SQRT_W'(1) << (SQRT_W - 2);
    end else if (busy_r) begin
      v_r <= ge ? (v_r - trial) : v_r;
      r_r <= ge ? ((r_r >> 1) + b_r) : (r_r >> 1);
      b_r <= b_r >> 2;
    end
  end

  assign done = done_r;
  assign root = r_r[ROOT_W-1:0];

endmodule
